[hw/rtl/ades_pkg.sv]
// Package for the adjacency edge store: field widths, request and status
// codes, and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package ades_pkg;

   // Field widths of the request and response words
   localparam int REQ_W    = 2;
   localparam int VTX_W    = 8;
   localparam int WEIGHT_W = 32;
   localparam int STATUS_W = 3;
   localparam int NBR_W    = 6;
   localparam int COUNT_W  = 7;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LIST   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_EDGE   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_VERTEX = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_EDGE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic                load_req;     // capture the request word, clear walk index
      logic                deg_rd_b;     // degree read address: second vertex
      logic                latch_deg_a;
      logic                latch_deg_b;
      logic                wr_a;         // append to first vertex list
      logic                wr_b;         // append to second vertex list
      logic                set_status;   // hold a pending single-word status
      logic [STATUS_W-1:0] status_code;
      logic                idx_step;     // advance walk index
      logic                rsp_single;   // load pending status as response
      logic                rsp_list;     // load current entry as list response
      logic                rsp_found;    // load current entry weight as found
   } ades_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic             a_ok;
      logic             b_ok;
      logic             deg_a_zero;
      logic             room;
      logic             walk_last;
      logic             match;
      logic             out_free;
   } ades_stat_type;

endpackage

`default_nettype wire

[hw/rtl/ades_req_if.sv]
// Request channel interface of the adjacency edge store.
// Depends on ades_pkg for field widths.
`default_nettype none

interface ades_req_if;
   logic                           valid;
   logic                           ready;
   logic [ades_pkg::REQ_W-1:0]     req_type;
   logic [ades_pkg::VTX_W-1:0]     first_vertex;
   logic [ades_pkg::VTX_W-1:0]     second_vertex;
   logic signed [ades_pkg::WEIGHT_W-1:0] edge_weight;

   modport source (output valid, req_type, first_vertex, second_vertex, edge_weight,
                   input ready);
   modport sink   (input valid, req_type, first_vertex, second_vertex, edge_weight,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/ades_rsp_if.sv]
// Response channel interface of the adjacency edge store.
// Depends on ades_pkg for field widths.
`default_nettype none

interface ades_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [ades_pkg::STATUS_W-1:0]        status;
   logic [ades_pkg::NBR_W-1:0]           neighbour_id;
   logic signed [ades_pkg::WEIGHT_W-1:0] found_weight;
   logic                                 last;

   modport source (output valid, status, neighbour_id, found_weight, last,
                   input ready);
   modport sink   (input valid, status, neighbour_id, found_weight, last,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/ades_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ades_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/ades_dp.sv]
// Datapath of the adjacency edge store: request and config registers, degree
// and entry memories, walk index and response register.
// Depends on ades_pkg and ades_ram.
`default_nettype none

module ades_dp #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_DEGREE   = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ades_pkg::ades_cmd_type               cmd,
   output      ades_pkg::ades_stat_type              stat,
   input  wire logic [ades_pkg::REQ_W-1:0]           req_type,
   input  wire logic [ades_pkg::VTX_W-1:0]           first_vertex,
   input  wire logic [ades_pkg::VTX_W-1:0]           second_vertex,
   input  wire logic signed [ades_pkg::WEIGHT_W-1:0] edge_weight,
   input  wire logic                                 csr_wr_en,
   input  wire logic [ades_pkg::COUNT_W-1:0]         csr_wr_data,
   input  wire logic                                 rsp_ready,
   output      logic                                 rsp_valid,
   output      logic [ades_pkg::STATUS_W-1:0]        rsp_status,
   output      logic [ades_pkg::NBR_W-1:0]           rsp_neighbour_id,
   output      logic signed [ades_pkg::WEIGHT_W-1:0] rsp_found_weight,
   output      logic                                 rsp_last
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int SW  = $clog2(MAX_DEGREE);
   localparam int DW  = $clog2(MAX_DEGREE + 2);
   localparam int WW  = ades_pkg::WEIGHT_W;
   localparam int NW  = ades_pkg::NBR_W;
   localparam int EW  = VW + WW;
   localparam int ENTRY_DEPTH = MAX_VERTICES * (2 ** SW);
   localparam logic [8:0]    VTX_LIM = 9'(MAX_VERTICES);
   localparam logic [DW-1:0] DEG_MAX = DW'(MAX_DEGREE);

   logic [ades_pkg::REQ_W-1:0]    type_ff;
   logic [ades_pkg::VTX_W-1:0]    a_ff, b_ff;
   logic [WW-1:0]                 w_ff;
   logic [ades_pkg::COUNT_W-1:0]  count_ff;
   logic [MAX_VERTICES-1:0]       vld_ff, vld_in;
   logic                          deg_vld_ff;
   logic [DW-1:0]                 deg_a_ff, deg_a_in, deg_b_ff, deg_b_in;
   logic [DW-1:0]                 idx_ff, idx_in;
   logic [ades_pkg::STATUS_W-1:0] pend_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ades_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [NW-1:0]                 rsp_id_ff, rsp_id_in;
   logic [WW-1:0]                 rsp_w_ff, rsp_w_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          out_free, rsp_load;

   logic [VW-1:0]    a_idx, b_idx;
   logic [VW-1:0]    deg_rd_addr, deg_wr_addr;
   logic [DW-1:0]    deg_rd_data, deg_wr_data, deg_rd_val;
   logic             deg_wr_en;
   logic [VW+SW-1:0] ent_wr_addr, ent_rd_addr;
   logic [EW-1:0]    ent_wr_data, ent_rd_data;
   logic [VW-1:0]    ent_id;
   logic [WW-1:0]    ent_w;
   logic             same;

   assign a_idx = a_ff[VW-1:0];
   assign b_idx = b_ff[VW-1:0];
   assign same  = (a_ff == b_ff);

   // Capture the request word
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         type_ff <= req_type;
         a_ff    <= first_vertex;
         b_ff    <= second_vertex;
         w_ff    <= edge_weight;
      end
   end

   // Vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= ades_pkg::COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Degree memory with one valid bit per vertex; invalid reads as zero
   assign deg_rd_addr = cmd.deg_rd_b ? b_idx : a_idx;
   assign deg_wr_en   = cmd.wr_a | cmd.wr_b;
   assign deg_wr_addr = cmd.wr_b ? b_idx : a_idx;
   assign deg_wr_data = cmd.wr_b ? deg_b_ff + DW'(1) : deg_a_ff + DW'(1);

   ades_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_deg_ram (
      .clock   (clock),
      .wr_en   (deg_wr_en),
      .wr_addr (deg_wr_addr),
      .wr_data (deg_wr_data),
      .rd_addr (deg_rd_addr),
      .rd_data (deg_rd_data)
   );

   always_comb begin
      vld_in = vld_ff;
      if (deg_wr_en) begin
         vld_in[deg_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Register the valid bit alongside the read so it matches the read word
   always_ff @(posedge clock) begin
      deg_vld_ff <= vld_ff[deg_rd_addr];
   end

   // Resolve degrees; a self-loop sees the first append already done
   always_comb begin
      deg_rd_val = deg_vld_ff ? deg_rd_data : '0;
      deg_a_in   = cmd.latch_deg_a ? deg_rd_val : deg_a_ff;
      deg_b_in   = deg_b_ff;
      if (cmd.latch_deg_b) begin
         deg_b_in = same ? deg_a_ff + DW'(1) : deg_rd_val;
      end
   end

   always_ff @(posedge clock) begin
      deg_a_ff <= deg_a_in;
      deg_b_ff <= deg_b_in;
   end

   // Walk index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.load_req) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // Entry memory: read address follows the next walk index
   assign ent_wr_addr = cmd.wr_b ? {b_idx, deg_b_ff[SW-1:0]} : {a_idx, deg_a_ff[SW-1:0]};
   assign ent_wr_data = cmd.wr_b ? {a_idx, w_ff} : {b_idx, w_ff};
   assign ent_rd_addr = {a_idx, idx_in[SW-1:0]};

   ades_ram #(.WIDTH(EW), .DEPTH(ENTRY_DEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (deg_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   assign ent_id = ent_rd_data[EW-1:WW];
   assign ent_w  = ent_rd_data[WW-1:0];

   // Pending single-word status
   always_ff @(posedge clock) begin
      if (cmd.set_status) begin
         pend_ff <= cmd.status_code;
      end
   end

   // Response register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = cmd.rsp_single | cmd.rsp_list | cmd.rsp_found;

   always_comb begin
      rsp_status_in = pend_ff;
      rsp_id_in     = '0;
      rsp_w_in      = '0;
      rsp_last_in   = 1'b1;
      if (cmd.rsp_list) begin
         rsp_status_in = ades_pkg::ST_OK;
         rsp_id_in     = NW'(ent_id);
         rsp_w_in      = ent_w;
         rsp_last_in   = stat.walk_last;
      end else if (cmd.rsp_found) begin
         rsp_status_in = ades_pkg::ST_OK;
         rsp_w_in      = ent_w;
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_w_ff      <= rsp_w_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_neighbour_id = rsp_id_ff;
   assign rsp_found_weight = rsp_w_ff;
   assign rsp_last         = rsp_last_ff;

   // Status toward the controller
   always_comb begin
      stat.req_type   = type_ff;
      stat.a_ok       = ({1'b0, a_ff} < {2'b00, count_ff}) && ({1'b0, a_ff} < VTX_LIM);
      stat.b_ok       = ({1'b0, b_ff} < {2'b00, count_ff}) && ({1'b0, b_ff} < VTX_LIM);
      stat.deg_a_zero = (deg_a_in == '0);
      stat.room       = (deg_a_ff < DEG_MAX) && (deg_b_in < DEG_MAX);
      stat.walk_last  = ((idx_ff + DW'(1)) == deg_a_ff);
      stat.match      = (ent_id == b_idx);
      stat.out_free   = out_free;
   end

endmodule

`default_nettype wire

[hw/rtl/ades_ctrl.sv]
// Controller of the adjacency edge store: sequences validity check, degree
// reads, appends and list walks. Depends on ades_pkg.
`default_nettype none

module ades_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire ades_pkg::ades_stat_type stat,
   output      ades_pkg::ades_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_RDA   = 3'd2;
   localparam logic [2:0] S_RDB   = 3'd3;
   localparam logic [2:0] S_WRA   = 3'd4;
   localparam logic [2:0] S_WRB   = 3'd5;
   localparam logic [2:0] S_WALK  = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [2:0] state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // Accept nothing while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.req_type == ades_pkg::REQ_VERTEX) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = stat.a_ok ? ades_pkg::ST_OK : ades_pkg::ST_INVALID;
               state_in        = S_EMIT;
            end else if (!stat.a_ok ||
                         (stat.req_type != ades_pkg::REQ_LIST && !stat.b_ok)) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ades_pkg::ST_INVALID;
               state_in        = S_EMIT;
            end else begin
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            cmd.latch_deg_a = 1'b1;
            cmd.deg_rd_b    = 1'b1;
            case (stat.req_type)
               ades_pkg::REQ_ADD: begin
                  state_in = S_RDB;
               end
               ades_pkg::REQ_LIST: begin
                  if (stat.deg_a_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ades_pkg::ST_EMPTY;
                     state_in        = S_EMIT;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               ades_pkg::REQ_EDGE: begin
                  if (stat.deg_a_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ades_pkg::ST_NO_EDGE;
                     state_in        = S_EMIT;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RDB: begin
            cmd.latch_deg_b = 1'b1;
            if (stat.room) begin
               state_in = S_WRA;
            end else begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ades_pkg::ST_FULL;
               state_in        = S_EMIT;
            end
         end
         S_WRA: begin
            cmd.wr_a = 1'b1;
            state_in = S_WRB;
         end
         S_WRB: begin
            cmd.wr_b        = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status_code = ades_pkg::ST_OK;
            state_in        = S_EMIT;
         end
         S_WALK: begin
            if (stat.req_type == ades_pkg::REQ_LIST) begin
               // One word per entry; hold the entry while the output stalls
               if (stat.out_free) begin
                  cmd.rsp_list = 1'b1;
                  if (stat.walk_last) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.idx_step = 1'b1;
                  end
               end
            end else if (stat.match) begin
               if (stat.out_free) begin
                  cmd.rsp_found = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (stat.walk_last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ades_pkg::ST_NO_EDGE;
               state_in        = S_EMIT;
            end else begin
               cmd.idx_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.rsp_single = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/adjacency_edge_store_top.sv]
// Top level of the adjacency edge store: controller, datapath and channels.
// Depends on ades_pkg, ades_req_if, ades_rsp_if, ades_ctrl and ades_dp.
//
//   port        dir  handshake           word
//   req_chan    in   valid/ready         req_type, first_vertex, second_vertex, edge_weight
//   rsp_chan    out  valid/ready         status, neighbour_id, found_weight, last
//   csr_*       in   csr_wr_en           csr_wr_data = vertex_count
//
// One request at a time, from its accepting cycle until the controller is idle
// again. A listing or edge query walks the list one entry per cycle (up to
// MAX_DEGREE entries), as the entry memory has a single read port; an empty
// list or a missing edge ends in a single status word.
// A stalled response holds the walk in place; ready stays low during reset.
// Reset clears the degree valid bits at once; no clearing pass is needed.
`default_nettype none

module adjacency_edge_store_top #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_DEGREE   = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   ades_req_if.sink                          req_chan,
   ades_rsp_if.source                        rsp_chan,
   input  wire logic                         csr_wr_en,
   input  wire logic [ades_pkg::COUNT_W-1:0] csr_wr_data
);

   ades_pkg::ades_cmd_type  cmd;
   ades_pkg::ades_stat_type stat;
   logic                    req_ready;

   // Sequencer
   ades_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // Storage and response word
   ades_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_DEGREE   (MAX_DEGREE)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_chan.req_type),
      .first_vertex     (req_chan.first_vertex),
      .second_vertex    (req_chan.second_vertex),
      .edge_weight      (req_chan.edge_weight),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_status       (rsp_chan.status),
      .rsp_neighbour_id (rsp_chan.neighbour_id),
      .rsp_found_weight (rsp_chan.found_weight),
      .rsp_last         (rsp_chan.last)
   );

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for adjacency_edge_store_top: graph requests in, status words out.
// Depends on ades_pkg, ades_req_if, ades_rsp_if and the store's RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_V       = 64;
   localparam int MAX_D       = 16;
   localparam int SETTLE      = 25;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [ades_pkg::REQ_W-1:0]    kind;
      logic [ades_pkg::VTX_W-1:0]    va;
      logic [ades_pkg::VTX_W-1:0]    vb;
      logic [ades_pkg::WEIGHT_W-1:0] weight;
   } graph_req_type;

   typedef struct {
      logic [ades_pkg::STATUS_W-1:0] status;
      logic [ades_pkg::NBR_W-1:0]    nbr;
      logic [ades_pkg::WEIGHT_W-1:0] weight;
      logic                          last;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                         csr_wr_en   = 1'b0;
   logic [ades_pkg::COUNT_W-1:0] csr_wr_data = '0;

   ades_req_if req_bus();
   ades_rsp_if rsp_bus();

   adjacency_edge_store_top #(
      .MAX_VERTICES(MAX_V),
      .MAX_DEGREE  (MAX_D)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_bus),
      .rsp_chan   (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Shadow copy of the graph and the vertex count register
   logic [ades_pkg::COUNT_W-1:0]  vertex_limit;
   logic [4:0]                    degree   [MAX_V];
   logic [ades_pkg::NBR_W-1:0]    list_ids [MAX_V*MAX_D];
   logic [ades_pkg::WEIGHT_W-1:0] list_wts [MAX_V*MAX_D];

   graph_req_type requests_waiting[$];
   answer_type    answers_due[$];
   graph_req_type cur_req;
   int         num_queued   = 0;
   int         num_accepted = 0;
   int         failures     = 0;
   int         cycle_count  = 0;
   int         burst_left   = 0;
   int         gap_left     = 0;
   logic [15:0] ready_mask  = 16'hFFFF;
   logic [5:0]  mask_pos    = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit vertex_valid(input logic [ades_pkg::VTX_W-1:0] v);
      return (int'(v) < int'(vertex_limit)) && (int'(v) < MAX_V);
   endfunction

   function automatic void push_answer(input logic [ades_pkg::STATUS_W-1:0] status,
                                       input logic [ades_pkg::NBR_W-1:0] nbr,
                                       input logic [ades_pkg::WEIGHT_W-1:0] weight,
                                       input logic last);
      answer_type ans;
      ans.status = status;
      ans.nbr    = nbr;
      ans.weight = weight;
      ans.last   = last;
      answers_due.push_back(ans);
   endfunction

   function automatic void append_entry(input int v, input logic [ades_pkg::NBR_W-1:0] id,
                                        input logic [ades_pkg::WEIGHT_W-1:0] weight);
      int slot;
      slot = v * MAX_D + int'(degree[v]);
      list_ids[slot] = id;
      list_wts[slot] = weight;
      degree[v] = degree[v] + 5'd1;
   endfunction

   // Apply one accepted request to the shadow graph and queue its answers
   function automatic void graph_apply(input graph_req_type rq);
      int  a;
      int  b;
      int  n;
      int  slot;
      bit  room;
      bit  hit;
      a = int'(rq.va);
      b = int'(rq.vb);
      hit = 1'b0;
      if (rq.kind == ades_pkg::REQ_VERTEX) begin
         push_answer(vertex_valid(rq.va) ? ades_pkg::ST_OK : ades_pkg::ST_INVALID,
                     '0, '0, 1'b1);
      end else if (!vertex_valid(rq.va) ||
                   (rq.kind != ades_pkg::REQ_LIST && !vertex_valid(rq.vb))) begin
         push_answer(ades_pkg::ST_INVALID, '0, '0, 1'b1);
      end else if (rq.kind == ades_pkg::REQ_ADD) begin
         if (a == b)
            room = int'(degree[a]) + 2 <= MAX_D;
         else
            room = int'(degree[a]) < MAX_D && int'(degree[b]) < MAX_D;
         if (!room) begin
            push_answer(ades_pkg::ST_FULL, '0, '0, 1'b1);
         end else begin
            append_entry(a, ades_pkg::NBR_W'(b), rq.weight);
            append_entry(b, ades_pkg::NBR_W'(a), rq.weight);
            push_answer(ades_pkg::ST_OK, '0, '0, 1'b1);
         end
      end else if (rq.kind == ades_pkg::REQ_LIST) begin
         n = int'(degree[a]);
         if (n == 0)
            push_answer(ades_pkg::ST_EMPTY, '0, '0, 1'b1);
         for (int i = 0; i < n; i++) begin
            slot = a * MAX_D + i;
            push_answer(ades_pkg::ST_OK, list_ids[slot], list_wts[slot], i + 1 == n);
         end
      end else begin
         // Edge query: first matching entry wins
         for (int i = 0; i < int'(degree[a]) && !hit; i++) begin
            slot = a * MAX_D + i;
            if (int'(list_ids[slot]) == b) begin
               push_answer(ades_pkg::ST_OK, '0, list_wts[slot], 1'b1);
               hit = 1'b1;
            end
         end
         if (!hit)
            push_answer(ades_pkg::ST_NO_EDGE, '0, '0, 1'b1);
      end
   endfunction

   function automatic void queue_req(input logic [ades_pkg::REQ_W-1:0] kind, input int a,
                                     input int b,
                                     input logic [ades_pkg::WEIGHT_W-1:0] weight);
      graph_req_type rq;
      rq.kind   = kind;
      rq.va     = ades_pkg::VTX_W'(a);
      rq.vb     = ades_pkg::VTX_W'(b);
      rq.weight = weight;
      requests_waiting.push_back(rq);
      num_queued++;
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10)
         $display("[%0t] %s", $time, msg);
   endfunction

   // Mostly a dense cluster of vertices, some spread, some out of range
   function automatic int pick_vertex(input int base);
      int eff;
      int r;
      eff = (int'(vertex_limit) > MAX_V) ? MAX_V : int'(vertex_limit);
      r = $urandom_range(0, 99);
      if (eff == 0 || r >= 90)
         return $urandom_range(0, 255);
      if (r >= 84)
         return eff;
      if (r >= 50)
         return $urandom_range(0, eff - 1);
      return (base + $urandom_range(0, 5)) % eff;
   endfunction

   function automatic logic [ades_pkg::WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic void random_phase(input int base, input int count);
      int r;
      logic [ades_pkg::REQ_W-1:0] kind;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            kind = ades_pkg::REQ_ADD;
         else if (r < 60)
            kind = ades_pkg::REQ_LIST;
         else if (r < 88)
            kind = ades_pkg::REQ_EDGE;
         else
            kind = ades_pkg::REQ_VERTEX;
         queue_req(kind, pick_vertex(base), pick_vertex(base), pick_weight());
      end
   endfunction

   // Hold until every word is accepted and answered, then let the block settle
   task automatic wait_idle();
      while (num_accepted != num_queued || answers_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_vertex_count(input logic [ades_pkg::COUNT_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      vertex_limit = value;
   endtask

   // Sender: bursts of words separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = $urandom_range(1, 12);
         gap_left   = 0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (req_bus.valid) begin
            graph_apply(cur_req);
            num_accepted++;
         end
         if (gap_left > 0 || requests_waiting.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_bus.valid <= 1'b0;
         end else begin
            cur_req = requests_waiting.pop_front();
            req_bus.req_type      <= cur_req.kind;
            req_bus.first_vertex  <= cur_req.va;
            req_bus.second_vertex <= cur_req.vb;
            req_bus.edge_weight   <= cur_req.weight;
            req_bus.valid         <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Receiver: stall on a random 16-bit ready mask, reselected each time the 6-bit mask position wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mask_pos == 0) begin
            ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            if (ready_mask == 0)
               ready_mask = 16'h8001;
         end
         rsp_bus.ready <= ready_mask[mask_pos[3:0]];
         mask_pos = mask_pos + 6'd1;
      end
   end

   // Check each response word against the oldest prediction
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (answers_due.size() == 0) begin
            note_failure($sformatf("unexpected word: status %0d id %0d weight %h last %0b",
                                   rsp_bus.status, rsp_bus.neighbour_id,
                                   rsp_bus.found_weight, rsp_bus.last));
         end else begin
            want = answers_due.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.neighbour_id !== want.nbr ||
                rsp_bus.found_weight !== want.weight || rsp_bus.last !== want.last)
               note_failure($sformatf(
                  "mismatch: expected status %0d id %0d weight %h last %0b, got %0d %0d %h %0b",
                  want.status, want.nbr, want.weight, want.last, rsp_bus.status,
                  rsp_bus.neighbour_id, rsp_bus.found_weight, rsp_bus.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.req_type      = '0;
      req_bus.first_vertex  = '0;
      req_bus.second_vertex = '0;
      req_bus.edge_weight   = '0;
      rsp_bus.ready         = 1'b0;
      vertex_limit          = ades_pkg::COUNT_RESET;
      for (int v = 0; v < MAX_V; v++)
         degree[v] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset count: range edges, empty list, self-loop, lookups, bad endpoints
      queue_req(ades_pkg::REQ_VERTEX, 0, 0, '0);
      queue_req(ades_pkg::REQ_VERTEX, 64, 0, '0);
      queue_req(ades_pkg::REQ_VERTEX, 255, 255, '0);
      queue_req(ades_pkg::REQ_LIST, 0, 0, '0);
      queue_req(ades_pkg::REQ_ADD, 0, 63, 32'h7FFF_FFFF);
      queue_req(ades_pkg::REQ_ADD, 5, 5, 32'h8000_0000);
      queue_req(ades_pkg::REQ_ADD, 0, 5, 32'hFFFF_FFFF);
      queue_req(ades_pkg::REQ_LIST, 0, 0, '0);
      queue_req(ades_pkg::REQ_LIST, 5, 0, '0);
      queue_req(ades_pkg::REQ_EDGE, 0, 63, '0);
      queue_req(ades_pkg::REQ_EDGE, 5, 5, '0);
      queue_req(ades_pkg::REQ_EDGE, 0, 1, '0);
      queue_req(ades_pkg::REQ_ADD, 0, 64, 32'h1234_5678);
      queue_req(ades_pkg::REQ_LIST, 64, 0, '0);
      queue_req(ades_pkg::REQ_EDGE, 0, 200, '0);
      queue_req(ades_pkg::REQ_LIST, 1, 255, '0);
      wait_idle();

      // Three vertices: nearly fill vertex 2, refuse a self-loop, fill it, then refuse further adds
      set_vertex_count(7'd3);
      queue_req(ades_pkg::REQ_ADD, 2, 1, 32'h0000_0001);
      for (int i = 0; i < 7; i++)
         queue_req(ades_pkg::REQ_ADD, 2, 2, pick_weight());
      queue_req(ades_pkg::REQ_ADD, 2, 2, 32'h5555_AAAA);
      queue_req(ades_pkg::REQ_ADD, 2, 0, 32'hAAAA_5555);
      queue_req(ades_pkg::REQ_ADD, 0, 2, 32'h0F0F_0F0F);
      queue_req(ades_pkg::REQ_LIST, 2, 0, '0);
      wait_idle();

      set_vertex_count(7'd64);
      random_phase(10, 40);
      wait_idle();
      set_vertex_count(7'd1);
      random_phase(0, 20);
      wait_idle();
      set_vertex_count(7'd0);
      random_phase(0, 15);
      wait_idle();
      set_vertex_count(7'd127);
      random_phase(30, 35);
      wait_idle();
      set_vertex_count(7'd4);
      random_phase(0, 35);
      wait_idle();
      set_vertex_count(7'd20);
      random_phase(12, 30);
      wait_idle();
      set_vertex_count(7'd64);
      random_phase(50, 25);
      wait_idle();

      if (failures == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/ades_pkg.sv
hw/rtl/ades_req_if.sv
hw/rtl/ades_rsp_if.sv
hw/rtl/ades_ram.sv
hw/rtl/ades_dp.sv
hw/rtl/ades_ctrl.sv
hw/rtl/adjacency_edge_store_top.sv
test/tb_top.sv
